/* src/stt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shader source tokenizer package
// Scanner modes, character codes, token class codes and operator lookups.
// ----------------------------------------------------------------------------
package stt_pkg;

    typedef enum logic [3:0] {
        M_IDLE,
        M_HOLD,
        M_NUMBER,
        M_WORD,
        M_STRING,
        M_LINECMT,
        M_BLOCK,
        M_BLOCKSTAR,
        M_UTF8
    } t_mode;

    localparam int unsigned LEN_BITS   = 16;
    localparam int unsigned CLASS_BITS = 6;
    localparam int unsigned MAX_TOKENS = 3;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_PCT        = 8'h25;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_LT         = 8'h3C;
    localparam logic [7:0] CH_EQ         = 8'h3D;
    localparam logic [7:0] CH_GT         = 8'h3E;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_BSLASH     = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    localparam logic [5:0] CLS_EOF        = 6'd0;
    localparam logic [5:0] CLS_NUMBER     = 6'd1;
    localparam logic [5:0] CLS_WORD       = 6'd2;
    localparam logic [5:0] CLS_STRING     = 6'd3;
    localparam logic [5:0] CLS_UNKNOWN    = 6'd4;
    localparam logic [5:0] CLS_DIV_ASSIGN = 6'd23;
    localparam logic [5:0] CLS_DOT        = 6'd53;
    localparam logic [5:0] CLS_ELLIPSIS   = 6'd54;

    function automatic logic [5:0] single_class(input logic [7:0] b);
        case (b)
            8'h7B:   single_class = 6'd5;
            8'h7D:   single_class = 6'd6;
            8'h5B:   single_class = 6'd7;
            8'h5D:   single_class = 6'd8;
            8'h28:   single_class = 6'd9;
            8'h29:   single_class = 6'd10;
            8'h2C:   single_class = 6'd11;
            8'h3B:   single_class = 6'd12;
            8'h7E:   single_class = 6'd13;
            8'h3F:   single_class = 6'd14;
            8'h5C:   single_class = 6'd15;
            default: single_class = 6'd0;
        endcase
    endfunction

    function automatic logic [5:0] held_class(input logic [7:0] b);
        case (b)
            8'h23:   held_class = 6'd16;
            8'h3A:   held_class = 6'd18;
            8'h2A:   held_class = 6'd20;
            8'h2F:   held_class = 6'd22;
            8'h25:   held_class = 6'd24;
            8'h21:   held_class = 6'd26;
            8'h3D:   held_class = 6'd28;
            8'h2B:   held_class = 6'd30;
            8'h2D:   held_class = 6'd33;
            8'h26:   held_class = 6'd36;
            8'h5E:   held_class = 6'd39;
            8'h7C:   held_class = 6'd42;
            8'h3C:   held_class = 6'd45;
            8'h3E:   held_class = 6'd49;
            8'h2E:   held_class = 6'd53;
            default: held_class = 6'd0;
        endcase
    endfunction

endpackage

/* src/stt_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shader source tokenizer scanner
// Front end: takes one source byte per transaction, updates the scanner
// state and produces up to three token entries for the queue.
// ----------------------------------------------------------------------------
module stt_scanner #(
    parameter int unsigned OFFSET_BITS = 32,
    parameter int unsigned LINE_BITS   = 20,
    parameter int unsigned COLUMN_BITS = 16,
    parameter int unsigned ENTRY_BITS  = 6 + 32 + 20 + 16 + 16 + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_is_end,
    output logic [1:0]            o_push_n,
    output logic [ENTRY_BITS-1:0] o_push_data [stt_pkg::MAX_TOKENS]
);

    localparam int unsigned LB = stt_pkg::LEN_BITS;

    stt_pkg::t_mode          r_mode, n_mode;
    logic [7:0]              r_hb, n_hb;
    logic [1:0]              r_cnt, n_cnt;
    logic [OFFSET_BITS-1:0]  r_tso, n_tso;
    logic [LINE_BITS-1:0]    r_tsl, n_tsl;
    logic [COLUMN_BITS-1:0]  r_tsc, n_tsc;
    logic [LB-1:0]           r_len, n_len;
    logic [OFFSET_BITS-1:0]  r_off, n_off;
    logic [LINE_BITS-1:0]    r_line, n_line;
    logic [COLUMN_BITS-1:0]  r_col, n_col;
    logic [1:0]              r_urem, n_urem;
    logic                    r_esc, n_esc;

    function automatic logic [ENTRY_BITS-1:0] mk(
        input logic [5:0]             cls,
        input logic [OFFSET_BITS-1:0] off,
        input logic [LINE_BITS-1:0]   line,
        input logic [COLUMN_BITS-1:0] col,
        input logic [LB-1:0]          len,
        input logic                   bad,
        input logic                   last
    );
        mk = {cls, off, line, col, len, bad, last};
    endfunction

    always_comb begin
        logic [7:0]  b;
        logic        done;
        logic        hit;
        logic        to_idle;
        logic [1:0]  n;
        logic [5:0]  base;
        logic [5:0]  sc;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic        alnum;
        b = i_data_byte;
        n_mode = r_mode;
        n_hb = r_hb;
        n_cnt = r_cnt;
        n_tso = r_tso;
        n_tsl = r_tsl;
        n_tsc = r_tsc;
        n_len = r_len;
        n_off = r_off;
        n_line = r_line;
        n_col = r_col;
        n_urem = r_urem;
        n_esc = r_esc;
        n = 2'd0;
        done = 1'b0;
        hit = 1'b0;
        to_idle = 1'b0;
        base = 6'd0;
        sc = 6'd0;
        lo = 8'h80;
        hi = 8'hBF;
        alnum = ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h61) && (b <= 8'h7A))
            || ((b >= 8'h41) && (b <= 8'h5A)) || (b == stt_pkg::CH_UNDERSCORE);
        for (int i = 0; i < stt_pkg::MAX_TOKENS; i++) begin
            o_push_data[i] = '0;
        end
        if (i_is_end) begin
            base = stt_pkg::held_class(r_hb);
            case (r_mode)
                stt_pkg::M_HOLD: begin
                    if (r_cnt == 2'd2) begin
                        if (r_hb == stt_pkg::CH_DOT) begin
                            o_push_data[n] = mk(stt_pkg::CLS_DOT, r_tso, r_tsl, r_tsc,
                                LB'(1), 1'b0, 1'b0);
                            n = n + 2'd1;
                            o_push_data[n] = mk(stt_pkg::CLS_DOT,
                                (r_tso == '1) ? r_tso : r_tso + 1'b1, r_tsl,
                                (r_tsc == '1) ? r_tsc : r_tsc + 1'b1,
                                LB'(1), 1'b0, 1'b0);
                            n = n + 2'd1;
                        end else begin
                            o_push_data[n] = mk(base + 6'd1, r_tso, r_tsl, r_tsc,
                                LB'(2), 1'b0, 1'b0);
                            n = n + 2'd1;
                        end
                    end else begin
                        o_push_data[n] = mk(base, r_tso, r_tsl, r_tsc, LB'(1), 1'b0, 1'b0);
                        n = n + 2'd1;
                    end
                end
                stt_pkg::M_NUMBER: begin
                    o_push_data[n] = mk(stt_pkg::CLS_NUMBER, r_tso, r_tsl, r_tsc, r_len,
                        1'b0, 1'b0);
                    n = n + 2'd1;
                end
                stt_pkg::M_WORD: begin
                    o_push_data[n] = mk(stt_pkg::CLS_WORD, r_tso, r_tsl, r_tsc, r_len,
                        1'b0, 1'b0);
                    n = n + 2'd1;
                end
                stt_pkg::M_STRING: begin
                    o_push_data[n] = mk(stt_pkg::CLS_STRING, r_tso, r_tsl, r_tsc, r_len,
                        1'b0, 1'b0);
                    n = n + 2'd1;
                end
                stt_pkg::M_UTF8: begin
                    o_push_data[n] = mk(stt_pkg::CLS_UNKNOWN, r_tso, r_tsl, r_tsc, r_len,
                        1'b1, 1'b0);
                    n = n + 2'd1;
                end
                default: begin
                end
            endcase
            o_push_data[n] = mk(stt_pkg::CLS_EOF, r_off, r_line, r_col, '0, 1'b0, 1'b1);
            n = n + 2'd1;
            n_mode = stt_pkg::M_IDLE;
            n_hb = '0;
            n_cnt = '0;
            n_tso = '0;
            n_tsl = LINE_BITS'(1);
            n_tsc = COLUMN_BITS'(1);
            n_len = '0;
            n_off = '0;
            n_line = LINE_BITS'(1);
            n_col = COLUMN_BITS'(1);
            n_urem = '0;
            n_esc = 1'b0;
        end else begin
            for (int p = 0; p < 3; p++) begin
                if (!done) begin
                    hit = 1'b0;
                    to_idle = 1'b0;
                    case (n_mode)
                        stt_pkg::M_IDLE: begin
                            done = 1'b1;
                            sc = stt_pkg::single_class(b);
                            base = stt_pkg::held_class(b);
                            if ((b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D))
                                    || (b == stt_pkg::CH_NUL)) begin
                            end else if (alnum || (b == stt_pkg::CH_DQUOTE)) begin
                                if ((b >= 8'h30) && (b <= 8'h39)) begin
                                    n_mode = stt_pkg::M_NUMBER;
                                end else if (b == stt_pkg::CH_DQUOTE) begin
                                    n_mode = stt_pkg::M_STRING;
                                    n_esc = 1'b0;
                                end else begin
                                    n_mode = stt_pkg::M_WORD;
                                end
                                n_tso = r_off;
                                n_tsl = r_line;
                                n_tsc = r_col;
                                n_len = LB'(1);
                            end else if (sc != 6'd0) begin
                                o_push_data[n] = mk(sc, r_off, r_line, r_col, LB'(1),
                                    1'b0, 1'b0);
                                n = n + 2'd1;
                            end else if (base != 6'd0) begin
                                n_mode = stt_pkg::M_HOLD;
                                n_tso = r_off;
                                n_tsl = r_line;
                                n_tsc = r_col;
                                n_len = LB'(1);
                                n_hb = b;
                                n_cnt = 2'd1;
                            end else if (b < 8'h80) begin
                                o_push_data[n] = mk(stt_pkg::CLS_UNKNOWN, r_off, r_line,
                                    r_col, LB'(1), 1'b0, 1'b0);
                                n = n + 2'd1;
                            end else if ((b >= 8'hC2) && (b <= 8'hF4)) begin
                                n_mode = stt_pkg::M_UTF8;
                                n_tso = r_off;
                                n_tsl = r_line;
                                n_tsc = r_col;
                                n_len = LB'(1);
                                n_hb = b;
                                n_urem = (b < 8'hE0) ? 2'd1 : ((b < 8'hF0) ? 2'd2 : 2'd3);
                            end else begin
                                o_push_data[n] = mk(stt_pkg::CLS_UNKNOWN, r_off, r_line,
                                    r_col, LB'(1), 1'b1, 1'b0);
                                n = n + 2'd1;
                            end
                        end
                        stt_pkg::M_HOLD: begin
                            base = stt_pkg::held_class(n_hb);
                            if (n_cnt == 2'd2) begin
                                if (n_hb == stt_pkg::CH_DOT) begin
                                    if (b == stt_pkg::CH_DOT) begin
                                        o_push_data[n] = mk(stt_pkg::CLS_ELLIPSIS, n_tso,
                                            n_tsl, n_tsc, LB'(3), 1'b0, 1'b0);
                                        n = n + 2'd1;
                                        to_idle = 1'b1;
                                        done = 1'b1;
                                    end else begin
                                        o_push_data[n] = mk(stt_pkg::CLS_DOT, n_tso,
                                            n_tsl, n_tsc, LB'(1), 1'b0, 1'b0);
                                        n = n + 2'd1;
                                        n_tso = (n_tso == '1) ? n_tso : n_tso + 1'b1;
                                        n_tsc = (n_tsc == '1) ? n_tsc : n_tsc + 1'b1;
                                        n_cnt = 2'd1;
                                    end
                                end else if (b == stt_pkg::CH_EQ) begin
                                    o_push_data[n] = mk(base + 6'd2, n_tso, n_tsl, n_tsc,
                                        LB'(3), 1'b0, 1'b0);
                                    n = n + 2'd1;
                                    to_idle = 1'b1;
                                    done = 1'b1;
                                end else begin
                                    o_push_data[n] = mk(base + 6'd1, n_tso, n_tsl, n_tsc,
                                        LB'(2), 1'b0, 1'b0);
                                    n = n + 2'd1;
                                    to_idle = 1'b1;
                                end
                            end else begin
                                case (n_hb)
                                    stt_pkg::CH_DOT: begin
                                        if ((b >= 8'h30) && (b <= 8'h39)) begin
                                            n_mode = stt_pkg::M_NUMBER;
                                            n_hb = '0;
                                            n_cnt = '0;
                                            n_len = LB'(2);
                                            hit = 1'b1;
                                        end else if (b == stt_pkg::CH_DOT) begin
                                            n_cnt = 2'd2;
                                            hit = 1'b1;
                                        end
                                    end
                                    stt_pkg::CH_SLASH: begin
                                        if ((b == stt_pkg::CH_SLASH)
                                                || (b == stt_pkg::CH_STAR)) begin
                                            n_mode = (b == stt_pkg::CH_SLASH)
                                                ? stt_pkg::M_LINECMT : stt_pkg::M_BLOCK;
                                            n_hb = '0;
                                            n_cnt = '0;
                                            n_len = '0;
                                            hit = 1'b1;
                                        end else if (b == stt_pkg::CH_EQ) begin
                                            o_push_data[n] = mk(stt_pkg::CLS_DIV_ASSIGN,
                                                n_tso, n_tsl, n_tsc, LB'(2), 1'b0, 1'b0);
                                            n = n + 2'd1;
                                            to_idle = 1'b1;
                                            hit = 1'b1;
                                        end
                                    end
                                    stt_pkg::CH_HASH, stt_pkg::CH_COLON: begin
                                        if (b == n_hb) begin
                                            o_push_data[n] = mk(base + 6'd1, n_tso, n_tsl,
                                                n_tsc, LB'(2), 1'b0, 1'b0);
                                            n = n + 2'd1;
                                            to_idle = 1'b1;
                                            hit = 1'b1;
                                        end
                                    end
                                    stt_pkg::CH_STAR, stt_pkg::CH_PCT, stt_pkg::CH_BANG,
                                    stt_pkg::CH_EQ: begin
                                        if (b == stt_pkg::CH_EQ) begin
                                            o_push_data[n] = mk(base + 6'd1, n_tso, n_tsl,
                                                n_tsc, LB'(2), 1'b0, 1'b0);
                                            n = n + 2'd1;
                                            to_idle = 1'b1;
                                            hit = 1'b1;
                                        end
                                    end
                                    stt_pkg::CH_LT, stt_pkg::CH_GT: begin
                                        if (b == n_hb) begin
                                            n_cnt = 2'd2;
                                            hit = 1'b1;
                                        end else if (b == stt_pkg::CH_EQ) begin
                                            o_push_data[n] = mk(base + 6'd3, n_tso, n_tsl,
                                                n_tsc, LB'(2), 1'b0, 1'b0);
                                            n = n + 2'd1;
                                            to_idle = 1'b1;
                                            hit = 1'b1;
                                        end
                                    end
                                    default: begin
                                        if ((b == n_hb) || (b == stt_pkg::CH_EQ)) begin
                                            o_push_data[n] = mk((b == n_hb) ? base + 6'd1
                                                : base + 6'd2, n_tso, n_tsl, n_tsc,
                                                LB'(2), 1'b0, 1'b0);
                                            n = n + 2'd1;
                                            to_idle = 1'b1;
                                            hit = 1'b1;
                                        end
                                    end
                                endcase
                                if (hit) begin
                                    done = 1'b1;
                                end else begin
                                    o_push_data[n] = mk(base, n_tso, n_tsl, n_tsc, LB'(1),
                                        1'b0, 1'b0);
                                    n = n + 2'd1;
                                    to_idle = 1'b1;
                                end
                            end
                        end
                        stt_pkg::M_NUMBER, stt_pkg::M_WORD: begin
                            if (alnum || ((n_mode == stt_pkg::M_NUMBER)
                                    && (b == stt_pkg::CH_DOT))) begin
                                n_len = (n_len == '1) ? n_len : n_len + 1'b1;
                                done = 1'b1;
                            end else begin
                                o_push_data[n] = mk((n_mode == stt_pkg::M_NUMBER)
                                    ? stt_pkg::CLS_NUMBER : stt_pkg::CLS_WORD,
                                    n_tso, n_tsl, n_tsc, n_len, 1'b0, 1'b0);
                                n = n + 2'd1;
                                to_idle = 1'b1;
                            end
                        end
                        stt_pkg::M_STRING: begin
                            done = 1'b1;
                            n_len = (n_len == '1) ? n_len : n_len + 1'b1;
                            if (n_esc) begin
                                n_esc = 1'b0;
                            end else if (b == stt_pkg::CH_BSLASH) begin
                                n_esc = 1'b1;
                            end else if (b == stt_pkg::CH_DQUOTE) begin
                                o_push_data[n] = mk(stt_pkg::CLS_STRING, n_tso, n_tsl,
                                    n_tsc, n_len, 1'b0, 1'b0);
                                n = n + 2'd1;
                                to_idle = 1'b1;
                            end
                        end
                        stt_pkg::M_LINECMT: begin
                            done = 1'b1;
                            if (b == stt_pkg::CH_LF) begin
                                n_mode = stt_pkg::M_IDLE;
                            end
                        end
                        stt_pkg::M_BLOCK: begin
                            done = 1'b1;
                            if (b == stt_pkg::CH_STAR) begin
                                n_mode = stt_pkg::M_BLOCKSTAR;
                            end
                        end
                        stt_pkg::M_BLOCKSTAR: begin
                            done = 1'b1;
                            if (b == stt_pkg::CH_SLASH) begin
                                n_mode = stt_pkg::M_IDLE;
                            end else if (b != stt_pkg::CH_STAR) begin
                                n_mode = stt_pkg::M_BLOCK;
                            end
                        end
                        stt_pkg::M_UTF8: begin
                            lo = 8'h80;
                            hi = 8'hBF;
                            if (n_len == LB'(1)) begin
                                if (n_hb == 8'hE0) begin
                                    lo = 8'hA0;
                                end else if (n_hb == 8'hED) begin
                                    hi = 8'h9F;
                                end else if (n_hb == 8'hF0) begin
                                    lo = 8'h90;
                                end else if (n_hb == 8'hF4) begin
                                    hi = 8'h8F;
                                end
                            end
                            if ((b >= lo) && (b <= hi) && (n_urem != 2'd0)) begin
                                done = 1'b1;
                                n_len = (n_len == '1) ? n_len : n_len + 1'b1;
                                n_urem = n_urem - 2'd1;
                                if (n_urem == 2'd0) begin
                                    o_push_data[n] = mk(stt_pkg::CLS_UNKNOWN, n_tso, n_tsl,
                                        n_tsc, n_len, 1'b0, 1'b0);
                                    n = n + 2'd1;
                                    to_idle = 1'b1;
                                end
                            end else begin
                                o_push_data[n] = mk(stt_pkg::CLS_UNKNOWN, n_tso, n_tsl,
                                    n_tsc, n_len, 1'b1, 1'b0);
                                n = n + 2'd1;
                                to_idle = 1'b1;
                            end
                        end
                        default: begin
                            to_idle = 1'b1;
                        end
                    endcase
                    if (to_idle) begin
                        n_mode = stt_pkg::M_IDLE;
                        n_hb = '0;
                        n_cnt = '0;
                        n_urem = '0;
                        n_esc = 1'b0;
                        n_len = '0;
                    end
                end
            end
            n_off = (r_off == '1) ? r_off : r_off + 1'b1;
            if (b == stt_pkg::CH_LF) begin
                n_line = (r_line == '1) ? r_line : r_line + 1'b1;
                n_col = COLUMN_BITS'(1);
            end else begin
                n_col = (r_col == '1) ? r_col : r_col + 1'b1;
            end
        end
        o_push_n = i_accept ? n : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= stt_pkg::M_IDLE;
            r_hb <= '0;
            r_cnt <= '0;
            r_tso <= '0;
            r_tsl <= LINE_BITS'(1);
            r_tsc <= COLUMN_BITS'(1);
            r_len <= '0;
            r_off <= '0;
            r_line <= LINE_BITS'(1);
            r_col <= COLUMN_BITS'(1);
            r_urem <= '0;
            r_esc <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_hb <= n_hb;
            r_cnt <= n_cnt;
            r_tso <= n_tso;
            r_tsl <= n_tsl;
            r_tsc <= n_tsc;
            r_len <= n_len;
            r_off <= n_off;
            r_line <= n_line;
            r_col <= n_col;
            r_urem <= n_urem;
            r_esc <= n_esc;
        end
    end

endmodule

/* src/stt_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shader source tokenizer token queue
// Eight-entry queue that takes up to three entries and gives one per cycle while popped.
// ----------------------------------------------------------------------------
module stt_queue #(
    parameter int unsigned ENTRY_BITS = 92
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_push_n,
    input  logic [ENTRY_BITS-1:0] i_push_data [stt_pkg::MAX_TOKENS],
    input  logic                  i_pop,
    output logic [ENTRY_BITS-1:0] o_head,
    output logic                  o_empty,
    output logic                  o_full
);

    localparam int unsigned DEPTH = 8;
    localparam int unsigned AW    = $clog2(DEPTH);

    logic [ENTRY_BITS-1:0] r_mem [DEPTH];
    logic [AW-1:0]         r_wr, n_wr;
    logic [AW-1:0]         r_rd, n_rd;
    logic [AW:0]           r_count, n_count;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count > (AW + 1)'(DEPTH - stt_pkg::MAX_TOKENS));

    always_comb begin
        n_wr = r_wr + AW'(i_push_n);
        n_rd = i_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count + (AW + 1)'(i_push_n) - (AW + 1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < stt_pkg::MAX_TOKENS; k++) begin
            if (k < int'(i_push_n)) begin
                r_mem[r_wr + AW'(k)] <= i_push_data[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW + 1)'(DEPTH)) else $error("queue count above depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |-> !o_full) else $error("push into full queue");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n == 2'd0) && !i_pop |=> $stable(r_count))
        else $error("queue count moved without traffic");
`endif

endmodule

/* src/stt_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shader source tokenizer output stage
// Back end: takes entries from the queue into the output register and holds
// them while the receiver stalls.
// ----------------------------------------------------------------------------
module stt_emit #(
    parameter int unsigned ENTRY_BITS = 92
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [ENTRY_BITS-1:0] i_head,
    input  logic                  i_empty,
    input  logic                  i_stall,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [ENTRY_BITS-1:0] o_data
);

    logic                  r_valid;
    logic [ENTRY_BITS-1:0] r_data;

    assign o_pop   = !i_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

endmodule

/* src/shader_source_tokenizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shader source tokenizer
// Streaming lexer for shader source text, one byte per transaction.
// ----------------------------------------------------------------------------
// Use: source bytes enter on the input channel (i_in_valid, o_in_stall) with
// i_is_end low; one transaction with i_is_end high closes the source, flushes
// any pending token and produces the end-of-file token with o_last_token set.
// Tokens leave on the output channel (o_out_valid, i_out_stall), one per
// transaction, with class, start offset, line, column, length and flags.
// A byte is taken every cycle while the token queue has room for three
// entries; the scanner state update, registered on each accepted byte, sets this.
// A token reaches the output through the queue and then the output register.
// A byte that completes several tokens fills the queue faster than one per
// cycle drains it, so bursts of short operators can briefly raise o_in_stall.
// When the receiver stalls, the output register holds its transaction, the
// queue fills and then o_in_stall rises; nothing is lost.
// Reset clears the scanner to its start of source position (line 1, column
// 1, offset 0) and empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module shader_source_tokenizer #(
    parameter int unsigned OFFSET_BITS = 32,
    parameter int unsigned LINE_BITS   = 20,
    parameter int unsigned COLUMN_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_is_end,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [5:0]             o_token_class,
    output logic [OFFSET_BITS-1:0] o_start_offset,
    output logic [LINE_BITS-1:0]   o_start_line,
    output logic [COLUMN_BITS-1:0] o_start_column,
    output logic [15:0]            o_token_bytes,
    output logic                   o_bad_utf8,
    output logic                   o_last_token
);

    localparam int unsigned ENTRY_BITS = stt_pkg::CLASS_BITS + OFFSET_BITS + LINE_BITS
        + COLUMN_BITS + stt_pkg::LEN_BITS + 2;

    logic                  accept;
    logic [1:0]            push_n;
    logic [ENTRY_BITS-1:0] push_data [stt_pkg::MAX_TOKENS];
    logic [ENTRY_BITS-1:0] head;
    logic                  empty;
    logic                  full;
    logic                  pop;
    logic [ENTRY_BITS-1:0] out_data;

    assign o_in_stall = full;
    assign accept = i_in_valid && !full;

    stt_scanner #(
        .OFFSET_BITS(OFFSET_BITS),
        .LINE_BITS  (LINE_BITS),
        .COLUMN_BITS(COLUMN_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_scanner (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_data_byte(i_data_byte),
        .i_is_end   (i_is_end),
        .o_push_n   (push_n),
        .o_push_data(push_data)
    );

    stt_queue #(
        .ENTRY_BITS(ENTRY_BITS)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_n   (push_n),
        .i_push_data(push_data),
        .i_pop      (pop),
        .o_head     (head),
        .o_empty    (empty),
        .o_full     (full)
    );

    stt_emit #(
        .ENTRY_BITS(ENTRY_BITS)
    ) u_emit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_head (head),
        .i_empty(empty),
        .i_stall(i_out_stall),
        .o_pop  (pop),
        .o_valid(o_out_valid),
        .o_data (out_data)
    );

    assign {o_token_class, o_start_offset, o_start_line, o_start_column,
            o_token_bytes, o_bad_utf8, o_last_token} = out_data;

endmodule

/* tb/shader_source_tokenizer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shader source tokenizer testbench
// Streams directed and random shader source through the tokenizer and
// compares every token with the output of a scanner model held in a
// scoreboard class, under random idling on both channels and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module shader_source_tokenizer_tb;

    typedef struct packed {
        logic [5:0]  cls;
        logic [31:0] off;
        logic [19:0] line;
        logic [15:0] col;
        logic [15:0] len;
        logic        bad;
        logic        last;
    } t_token;

    class t_token_scoreboard;
        stt_pkg::t_mode mode;
        logic [15:0]    held;
        logic [1:0]     nheld;
        logic [31:0]    t_off, off;
        logic [19:0]    t_line, line;
        logic [15:0]    t_col, col, t_len;
        logic [1:0]     u_rem;
        logic           esc;
        t_token         expected_tokens[$];
        int             errors;

        function void go_idle();
            mode = stt_pkg::M_IDLE;
            held = '0;
            nheld = '0;
            u_rem = '0;
            esc = 1'b0;
            t_len = '0;
        endfunction

        function void restart();
            go_idle();
            t_off = '0;
            t_line = 20'd1;
            t_col = 16'd1;
            off = '0;
            line = 20'd1;
            col = 16'd1;
        endfunction

        function new();
            errors = 0;
            restart();
        endfunction

        function void push(int cls, logic [31:0] o, logic [19:0] l, logic [15:0] c,
                           logic [15:0] len, logic bad, logic last);
            t_token t;
            t.cls = cls[5:0];
            t.off = o;
            t.line = l;
            t.col = c;
            t.len = len;
            t.bad = bad;
            t.last = last;
            expected_tokens = {expected_tokens, t};
        endfunction

        function void push_tok(int cls, logic [15:0] len, logic bad);
            push(cls, t_off, t_line, t_col, len, bad, 1'b0);
        endfunction

        function void begin_tok(stt_pkg::t_mode m, logic [31:0] o, logic [19:0] l,
                                logic [15:0] c);
            mode = m;
            t_off = o;
            t_line = l;
            t_col = c;
            t_len = 16'd1;
        endfunction

        function int lone_op(logic [7:0] b);
            case (b)
                "{": return 5;   "}": return 6;   "[": return 7;   "]": return 8;
                "(": return 9;   ")": return 10;  ",": return 11;  ";": return 12;
                "~": return 13;  "?": return 14;  "\\": return 15;
                default: return -1;
            endcase
        endfunction

        function int pair_op(logic [7:0] b);
            case (b)
                "#": return 16;  ":": return 18;  "*": return 20;  "/": return 22;
                "%": return 24;  "!": return 26;  "=": return 28;  "+": return 30;
                "-": return 33;  "&": return 36;  "^": return 39;  "|": return 42;
                "<": return 45;  ">": return 49;  ".": return 53;
                default: return -1;
            endcase
        endfunction

        function bit is_digit(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function bit is_alpha(logic [7:0] b);
            return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        endfunction

        function void scan_idle(logic [7:0] b, logic [31:0] o, logic [19:0] l,
                                logic [15:0] c);
            if (b == " " || (b >= 8'd9 && b <= 8'd13) || b == stt_pkg::CH_NUL) return;
            if (is_digit(b)) begin
                begin_tok(stt_pkg::M_NUMBER, o, l, c);
            end else if (is_alpha(b) || b == stt_pkg::CH_UNDERSCORE) begin
                begin_tok(stt_pkg::M_WORD, o, l, c);
            end else if (b == stt_pkg::CH_DQUOTE) begin
                begin_tok(stt_pkg::M_STRING, o, l, c);
                esc = 1'b0;
            end else if (lone_op(b) >= 0) begin
                push(lone_op(b), o, l, c, 16'd1, 1'b0, 1'b0);
            end else if (pair_op(b) >= 0) begin
                begin_tok(stt_pkg::M_HOLD, o, l, c);
                held = {8'h00, b};
                nheld = 2'd1;
            end else if (b < 8'h80) begin
                push(stt_pkg::CLS_UNKNOWN, o, l, c, 16'd1, 1'b0, 1'b0);
            end else if (b >= 8'hC2 && b <= 8'hF4) begin
                begin_tok(stt_pkg::M_UTF8, o, l, c);
                held = {8'h00, b};
                u_rem = b < 8'hE0 ? 2'd1 : (b < 8'hF0 ? 2'd2 : 2'd3);
            end else begin
                push(stt_pkg::CLS_UNKNOWN, o, l, c, 16'd1, 1'b1, 1'b0);
            end
        endfunction

        function bit scan_hold(logic [7:0] b);
            logic [7:0] c;
            int         base;
            c = held[7:0];
            base = pair_op(c);
            if (base < 0) begin
                base = stt_pkg::CLS_DOT;
                c = stt_pkg::CH_DOT;
            end
            if (nheld >= 2'd2) begin
                if (c == stt_pkg::CH_DOT) begin
                    if (b == stt_pkg::CH_DOT) begin
                        push_tok(stt_pkg::CLS_ELLIPSIS, 16'd3, 1'b0);
                        go_idle();
                        return 1;
                    end
                    push_tok(stt_pkg::CLS_DOT, 16'd1, 1'b0);
                    t_off = (t_off == '1) ? t_off : t_off + 1;
                    t_col = (t_col == '1) ? t_col : t_col + 1;
                    held = {8'h00, stt_pkg::CH_DOT};
                    nheld = 2'd1;
                    return 0;
                end
                if (b == stt_pkg::CH_EQ) begin
                    push_tok(base + 2, 16'd3, 1'b0);
                    go_idle();
                    return 1;
                end
                push_tok(base + 1, 16'd2, 1'b0);
                go_idle();
                return 0;
            end
            case (c)
                stt_pkg::CH_DOT: begin
                    if (is_digit(b)) begin
                        mode = stt_pkg::M_NUMBER;
                        held = '0;
                        nheld = '0;
                        t_len = 16'd2;
                        return 1;
                    end
                    if (b == stt_pkg::CH_DOT) begin
                        held = {c, c};
                        nheld = 2'd2;
                        return 1;
                    end
                end
                stt_pkg::CH_SLASH: begin
                    if (b == stt_pkg::CH_SLASH) begin
                        go_idle();
                        mode = stt_pkg::M_LINECMT;
                        return 1;
                    end
                    if (b == stt_pkg::CH_STAR) begin
                        go_idle();
                        mode = stt_pkg::M_BLOCK;
                        return 1;
                    end
                    if (b == stt_pkg::CH_EQ) begin
                        push_tok(stt_pkg::CLS_DIV_ASSIGN, 16'd2, 1'b0);
                        go_idle();
                        return 1;
                    end
                end
                stt_pkg::CH_HASH, stt_pkg::CH_COLON: begin
                    if (b == c) begin
                        push_tok(base + 1, 16'd2, 1'b0);
                        go_idle();
                        return 1;
                    end
                end
                stt_pkg::CH_STAR, stt_pkg::CH_PCT, stt_pkg::CH_BANG, stt_pkg::CH_EQ: begin
                    if (b == stt_pkg::CH_EQ) begin
                        push_tok(base + 1, 16'd2, 1'b0);
                        go_idle();
                        return 1;
                    end
                end
                stt_pkg::CH_LT, stt_pkg::CH_GT: begin
                    if (b == c) begin
                        held = {c, c};
                        nheld = 2'd2;
                        return 1;
                    end
                    if (b == stt_pkg::CH_EQ) begin
                        push_tok(base + 3, 16'd2, 1'b0);
                        go_idle();
                        return 1;
                    end
                end
                default: begin
                    if (b == c) begin
                        push_tok(base + 1, 16'd2, 1'b0);
                        go_idle();
                        return 1;
                    end
                    if (b == stt_pkg::CH_EQ) begin
                        push_tok(base + 2, 16'd2, 1'b0);
                        go_idle();
                        return 1;
                    end
                end
            endcase
            push_tok(base, 16'd1, 1'b0);
            go_idle();
            return 0;
        endfunction

        function void take(logic [7:0] b);
            logic [7:0] lo, hi, lead;
            while (1) begin
                case (mode)
                    stt_pkg::M_IDLE: begin
                        scan_idle(b, off, line, col);
                        return;
                    end
                    stt_pkg::M_HOLD: begin
                        if (scan_hold(b)) return;
                    end
                    stt_pkg::M_NUMBER, stt_pkg::M_WORD: begin
                        if (is_digit(b) || is_alpha(b) || b == stt_pkg::CH_UNDERSCORE ||
                            (mode == stt_pkg::M_NUMBER && b == stt_pkg::CH_DOT)) begin
                            t_len = (t_len == '1) ? t_len : t_len + 1;
                            return;
                        end
                        push_tok(mode == stt_pkg::M_NUMBER ? stt_pkg::CLS_NUMBER
                                 : stt_pkg::CLS_WORD, t_len, 1'b0);
                        go_idle();
                    end
                    stt_pkg::M_STRING: begin
                        t_len = (t_len == '1) ? t_len : t_len + 1;
                        if (esc) begin
                            esc = 1'b0;
                        end else if (b == stt_pkg::CH_BSLASH) begin
                            esc = 1'b1;
                        end else if (b == stt_pkg::CH_DQUOTE) begin
                            push_tok(stt_pkg::CLS_STRING, t_len, 1'b0);
                            go_idle();
                        end
                        return;
                    end
                    stt_pkg::M_LINECMT: begin
                        if (b == stt_pkg::CH_LF) mode = stt_pkg::M_IDLE;
                        return;
                    end
                    stt_pkg::M_BLOCK: begin
                        if (b == stt_pkg::CH_STAR) mode = stt_pkg::M_BLOCKSTAR;
                        return;
                    end
                    stt_pkg::M_BLOCKSTAR: begin
                        if (b == stt_pkg::CH_SLASH) mode = stt_pkg::M_IDLE;
                        else if (b != stt_pkg::CH_STAR) mode = stt_pkg::M_BLOCK;
                        return;
                    end
                    stt_pkg::M_UTF8: begin
                        lo = 8'h80;
                        hi = 8'hBF;
                        lead = held[7:0];
                        if (t_len == 16'd1) begin
                            if (lead == 8'hE0) lo = 8'hA0;
                            else if (lead == 8'hED) hi = 8'h9F;
                            else if (lead == 8'hF0) lo = 8'h90;
                            else if (lead == 8'hF4) hi = 8'h8F;
                        end
                        if (b >= lo && b <= hi && u_rem > 0) begin
                            t_len = (t_len == '1) ? t_len : t_len + 1;
                            u_rem = u_rem - 1;
                            if (u_rem == 0) begin
                                push_tok(stt_pkg::CLS_UNKNOWN, t_len, 1'b0);
                                go_idle();
                            end
                            return;
                        end
                        push_tok(stt_pkg::CLS_UNKNOWN, t_len, 1'b1);
                        go_idle();
                    end
                    default: go_idle();
                endcase
            end
        endfunction

        function void flush();
            logic [7:0] c;
            int         hc;
            case (mode)
                stt_pkg::M_HOLD: begin
                    c = held[7:0];
                    hc = pair_op(c);
                    if (hc < 0) hc = stt_pkg::CLS_DOT;
                    if (nheld >= 2'd2) begin
                        if (c == stt_pkg::CH_DOT || hc == stt_pkg::CLS_DOT) begin
                            push_tok(stt_pkg::CLS_DOT, 16'd1, 1'b0);
                            push(stt_pkg::CLS_DOT, (t_off == '1) ? t_off : t_off + 1, t_line,
                                 (t_col == '1) ? t_col : t_col + 1, 16'd1, 1'b0, 1'b0);
                        end else begin
                            push_tok(hc + 1, 16'd2, 1'b0);
                        end
                    end else begin
                        push_tok(hc, 16'd1, 1'b0);
                    end
                end
                stt_pkg::M_NUMBER: push_tok(stt_pkg::CLS_NUMBER, t_len, 1'b0);
                stt_pkg::M_WORD:   push_tok(stt_pkg::CLS_WORD, t_len, 1'b0);
                stt_pkg::M_STRING: push_tok(stt_pkg::CLS_STRING, t_len, 1'b0);
                stt_pkg::M_UTF8:   push_tok(stt_pkg::CLS_UNKNOWN, t_len, 1'b1);
                default: ;
            endcase
        endfunction

        function void note_input(logic [7:0] b, logic is_end);
            if (is_end) begin
                flush();
                push(stt_pkg::CLS_EOF, off, line, col, 16'd0, 1'b0, 1'b1);
                restart();
                return;
            end
            take(b);
            off = (off == '1) ? off : off + 1;
            if (b == stt_pkg::CH_LF) begin
                line = (line == '1) ? line : line + 1;
                col = 16'd1;
            end else begin
                col = (col == '1) ? col : col + 1;
            end
        endfunction

        function void check_token(t_token got);
            t_token want;
            if (expected_tokens.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected token %p", got);
                return;
            end
            want = expected_tokens.pop_front();
            if (got.cls !== want.cls || got.off !== want.off || got.line !== want.line ||
                got.col !== want.col || got.len !== want.len || got.bad !== want.bad ||
                got.last !== want.last) begin
                errors++;
                if (errors <= 10) $display("Token mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_is_end;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [5:0]  o_token_class;
    logic [31:0] o_start_offset;
    logic [19:0] o_start_line;
    logic [15:0] o_start_column;
    logic [15:0] o_token_bytes;
    logic        o_bad_utf8;
    logic        o_last_token;

    t_token_scoreboard scoreboard;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int bytes_sent;

    shader_source_tokenizer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_is_end       (i_is_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_token_class  (o_token_class),
        .o_start_offset (o_start_offset),
        .o_start_line   (o_start_line),
        .o_start_column (o_start_column),
        .o_token_bytes  (o_token_bytes),
        .o_bad_utf8     (o_bad_utf8),
        .o_last_token   (o_last_token)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(negedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = 200;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            scoreboard.check_token({o_token_class, o_start_offset, o_start_line,
                                    o_start_column, o_token_bytes, o_bad_utf8,
                                    o_last_token});
        end
    end

    task automatic send_byte(logic [7:0] b, logic is_end);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            i_data_byte <= 8'($urandom);
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_is_end <= is_end;
        do @(posedge i_clk); while (o_in_stall);
        scoreboard.note_input(b, is_end);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_byte(8'($urandom), 1'b1);
    endtask

    task automatic send_fragment();
        string ops[] = '{"{", "}", "[", "]", "(", ")", ",", ";", "~", "?", "\\", "#",
                         "##", ":", "::", "*", "*=", "/", "/=", "%", "%=", "!", "!=",
                         "=", "==", "+", "++", "+=", "-", "--", "-=", "&", "&&", "&=",
                         "^", "^^", "^=", "|", "||", "|=", "<", "<<", "<<=", "<=", ">",
                         ">>", ">>=", ">=", ".", "...", "..", ".5"};
        string words[] = '{"vec4", "_x1", "gl_Pos", "a", "Z9_z"};
        string nums[] = '{"0", "42", "3.14", "1e5", "0x1F", "9.", "7_u"};
        int    pick;
        int    n;
        pick = $urandom_range(99);
        if (pick < 30) begin
            send_text(ops[$urandom_range(ops.size() - 1)]);
        end else if (pick < 45) begin
            send_text(words[$urandom_range(words.size() - 1)]);
        end else if (pick < 55) begin
            send_text(nums[$urandom_range(nums.size() - 1)]);
        end else if (pick < 65) begin
            send_text($urandom_range(1) ? " " : "\n");
        end else if (pick < 70) begin
            send_text($urandom_range(1) ? "\"a\\\"b c\"" : "\"x\\\\\"");
        end else if (pick < 74) begin
            send_text($urandom_range(1) ? "// note *\n" : "/* a ** b */");
        end else if (pick < 80) begin
            n = $urandom_range(3);
            send_byte(n == 0 ? 8'hC3 : n == 1 ? 8'hE2 : n == 2 ? 8'hF0 : 8'hED, 1'b0);
            if (n == 0) send_byte(8'hA9, 1'b0);
            if (n == 1) begin
                send_byte(8'h82, 1'b0);
                send_byte(8'hAC, 1'b0);
            end
            if (n == 2) begin
                send_byte(8'h9F, 1'b0);
                send_byte(8'h98, 1'b0);
                send_byte(8'h80, 1'b0);
            end
            if (n == 3) send_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
        end else if (pick < 97) begin
            send_byte(8'($urandom), 1'b0);
        end else begin
            send_end();
        end
    endtask

    initial begin
        scoreboard = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_data_byte = 8'h00;
        i_is_end = 1'b0;
        i_out_stall = 1'b0;
        tx_idle_pct = 9;
        rx_idle_pct = 79;
        hold_requests = 0;
        hold_served = 0;
        hold_left = 0;
        bytes_sent = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        hold_requests++;
        send_text("a_1 9.5e+ .5 ..x ..3 ... <<= >>= :: ## a//c\n/*x**/\"s\\\"t\"\n");
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_end();
        send_text("<<");
        send_end();
        send_text("..");
        send_end();
        send_text("/* open");
        send_end();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_end();

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 79 : 0;
            rx_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 9 : 0;
            bytes_sent = 0;
            while (bytes_sent < 6) send_fragment();
        end
        send_end();
        i_in_valid <= 1'b0;

        while (scoreboard.expected_tokens.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (scoreboard.errors == 0 && scoreboard.expected_tokens.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
